// ----- hdl/mnta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnta_pkg
// Shared types, codes and defaults for the mesh neighbor table aging unit.
// ----------------------------------------------------------------------------
package mnta_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_MESSAGE_BYTES     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALE_TIMEOUT_MS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEARTBEAT_INTERVAL_MS = 2'd2;

    localparam logic [7:0]  MIN_MESSAGE_BYTES_RST     = 8'd14;
    localparam logic [31:0] STALE_TIMEOUT_MS_RST      = 32'd10000;
    localparam logic [31:0] HEARTBEAT_INTERVAL_MS_RST = 32'd3000;

    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TICK     = 3'd4;

    localparam logic ACT_RECEIVE = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [7:0]  msg_length;
        logic [47:0] sender_mac;
        logic        sender_is_root;
        logic [15:0] sender_universe;
        logic [15:0] sender_start_channel;
        logic [15:0] sender_led_count;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  entry_count;
        logic [COUNT_W-1:0]  removed_count;
        logic                heartbeat_due;
    } result_t;

    typedef struct packed {
        logic [47:0] address;
        logic [31:0] last_seen;
        logic        root_flag;
        logic [15:0] universe;
        logic [15:0] first_channel;
        logic [15:0] led_total;
    } entry_t;

endpackage

// ----- hdl/mesh_neighbor_table_aging_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_neighbor_table_aging_unit
// Neighbor table keyed by 48-bit address with per-entry aging and heartbeat.
// ----------------------------------------------------------------------------
// One beat in, one result beat out. The table sits in a single-port-write,
// single-read memory that is walked one entry at a time (read, then compare
// or age). A receive beat walks the valid entries until one matches and is
// updated, else it is inserted at the end or dropped when the table is full;
// a short message goes straight to its result. A tick first checks the
// heartbeat, then sweeps the table, in which the same 32-bit subtract and
// compare ages each entry and survivors are copied down in place. Each beat
// ends by handing its result to the output register, which holds it while
// the next beat is taken in; a result still stalled in that register keeps
// the sequencer from handing off the next one. The table is empty after
// reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module mesh_neighbor_table_aging_unit #(
    parameter int TABLE_ENTRIES = mnta_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mnta_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mnta_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  mnta_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output mnta_pkg::result_t                result
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HB   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_AGE  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [CNT_W-1:0] slot_reg, slot_next;
    logic [mnta_pkg::STATUS_W-1:0] status_reg, status_next;
    logic due_reg, due_next;
    logic [31:0] hb_reg, hb_next;

    logic [7:0]  min_len_reg;
    logic [31:0] timeout_reg;
    logic [31:0] interval_reg;

    mnta_pkg::item_t   item_reg;
    mnta_pkg::result_t result_reg, result_next;
    logic              result_valid_reg, result_valid_next;
    logic              load_result;

    mnta_pkg::entry_t entry_mem [TABLE_ENTRIES];
    mnta_pkg::entry_t rd_data_reg;
    mnta_pkg::entry_t fill_entry;
    mnta_pkg::entry_t mem_wd;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;

    logic        accept;
    logic [31:0] cmp_base;
    logic [31:0] cmp_limit;
    logic [31:0] cmp_age;
    logic        cmp_over;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // shared age unit: heartbeat check and entry aging
    assign cmp_base  = (state_reg == S_HB) ? hb_reg : rd_data_reg.last_seen;
    assign cmp_limit = (state_reg == S_HB) ? interval_reg : timeout_reg;
    assign cmp_age   = item_reg.now_ms - cmp_base;
    assign cmp_over  = (cmp_age > cmp_limit);

    assign fill_entry = '{
        address:       item_reg.sender_mac,
        last_seen:     item_reg.now_ms,
        root_flag:     item_reg.sender_is_root,
        universe:      item_reg.sender_universe,
        first_channel: item_reg.sender_start_channel,
        led_total:     item_reg.sender_led_count
    };

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        keep_next    = keep_reg;
        removed_next = removed_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        due_next     = due_reg;
        hb_next      = hb_reg;
        mem_we       = 1'b0;
        mem_wa       = idx_reg[IDX_W-1:0];
        mem_wd       = fill_entry;
        load_result  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next     = '0;
                    keep_next    = '0;
                    removed_next = '0;
                    slot_next    = '0;
                    due_next     = 1'b0;
                    state_next   = (item.action == mnta_pkg::ACT_TICK) ? S_HB : S_RD;
                end
            end
            S_HB:
            begin
                if (cmp_over)
                begin
                    due_next = 1'b1;
                    hb_next  = item_reg.now_ms;
                end
                state_next = S_RD;
            end
            S_RD:
            begin
                if (item_reg.action == mnta_pkg::ACT_TICK)
                begin
                    if (idx_reg == count_reg)
                    begin
                        count_next  = keep_reg;
                        status_next = mnta_pkg::ST_TICK;
                        state_next  = S_RES;
                    end
                    else
                    begin
                        state_next = S_AGE;
                    end
                end
                else if (item_reg.msg_length < min_len_reg)
                begin
                    status_next = mnta_pkg::ST_SHORT;
                    state_next  = S_RES;
                end
                else if (idx_reg == count_reg)
                begin
                    if (count_reg < CNT_MAX)
                    begin
                        mem_we      = 1'b1;
                        mem_wa      = count_reg[IDX_W-1:0];
                        slot_next   = count_reg;
                        count_next  = count_reg + 1'b1;
                        status_next = mnta_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        status_next = mnta_pkg::ST_FULL;
                    end
                    state_next = S_RES;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rd_data_reg.address == item_reg.sender_mac)
                begin
                    mem_we      = 1'b1;
                    slot_next   = idx_reg;
                    status_next = mnta_pkg::ST_UPDATED;
                    state_next  = S_RES;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_AGE:
            begin
                if (cmp_over)
                begin
                    removed_next = removed_reg + 1'b1;
                end
                else
                begin
                    if (keep_reg != idx_reg)
                    begin
                        mem_we = 1'b1;
                        mem_wa = keep_reg[IDX_W-1:0];
                        mem_wd = rd_data_reg;
                    end
                    keep_next = keep_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_RD;
            end
            S_RES:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    load_result = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_next               = result_reg;
        result_next.status        = status_reg;
        result_next.slot          = mnta_pkg::SLOT_W'(slot_reg);
        result_next.entry_count   = mnta_pkg::COUNT_W'(count_reg);
        result_next.removed_count = mnta_pkg::COUNT_W'(removed_reg);
        result_next.heartbeat_due = due_reg;

        if (load_result)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            keep_reg         <= '0;
            removed_reg      <= '0;
            slot_reg         <= '0;
            status_reg       <= mnta_pkg::ST_UPDATED;
            due_reg          <= 1'b0;
            hb_reg           <= '0;
            result_valid_reg <= 1'b0;
            min_len_reg      <= mnta_pkg::MIN_MESSAGE_BYTES_RST;
            timeout_reg      <= mnta_pkg::STALE_TIMEOUT_MS_RST;
            interval_reg     <= mnta_pkg::HEARTBEAT_INTERVAL_MS_RST;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            idx_reg          <= idx_next;
            keep_reg         <= keep_next;
            removed_reg      <= removed_next;
            slot_reg         <= slot_next;
            status_reg       <= status_next;
            due_reg          <= due_next;
            hb_reg           <= hb_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mnta_pkg::CFG_MIN_MESSAGE_BYTES:     min_len_reg  <= cfg_data[7:0];
                    mnta_pkg::CFG_STALE_TIMEOUT_MS:      timeout_reg  <= cfg_data;
                    mnta_pkg::CFG_HEARTBEAT_INTERVAL_MS: interval_reg <= cfg_data;
                    default:                             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        if (load_result)
            result_reg <= result_next;
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            entry_mem[mem_wa] <= mem_wd;
        rd_data_reg <= entry_mem[idx_reg[IDX_W-1:0]];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count beyond table size");

    a_keep_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AGE) |-> (keep_reg <= idx_reg))
        else $error("compaction write index ahead of read index");

    a_tick_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.status == mnta_pkg::ST_TICK))
        |-> (result_reg.slot == '0))
        else $error("tick beat carries nonzero slot");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RES && !load_result) |=> (state_reg == S_RES))
        else $error("sequencer left result state without handing off");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mesh_neighbor_table_aging_unit.
// Directed beats cover short messages, insert, update, a full table, the
// heartbeat boundary, stale sweeps with compaction and the register extremes.
// Random phases then run traffic from a small address pool against a running
// millisecond clock, with noise beats mixed in. An in-bench table model
// predicts every result beat; both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [mnta_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int unsigned MAX_IDLE    = 8;
    localparam int unsigned POOL_SIZE   = 24;
    localparam int unsigned PHASE_BEATS = 232;
    localparam int unsigned DRAIN_CYCLES = 60;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [mnta_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mnta_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             item_valid = 1'b0;
    logic                             item_stall;
    mnta_pkg::item_t                  in_beat = '0;
    logic                             result_valid;
    logic                             result_stall = 1'b0;
    mnta_pkg::result_t                out_beat;

    // neighbor table model
    mnta_pkg::entry_t nb_table [mnta_pkg::TABLE_ENTRIES_DEF];
    int unsigned      nb_count = 0;
    logic [31:0]      last_beat_ms = '0;
    logic [7:0]       min_len = mnta_pkg::MIN_MESSAGE_BYTES_RST;
    logic [31:0]      stale_limit = mnta_pkg::STALE_TIMEOUT_MS_RST;
    logic [31:0]      beat_interval = mnta_pkg::HEARTBEAT_INTERVAL_MS_RST;

    mnta_pkg::result_t pending_outcomes [$];
    int unsigned       mismatch_count = 0;
    int unsigned       out_hold = 0;
    bit                full_rate = 1'b0;

    mesh_neighbor_table_aging_unit #(
        .TABLE_ENTRIES (mnta_pkg::TABLE_ENTRIES_DEF)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (in_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (out_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("** mesh_neighbor_table_aging_unit: FAILED **");
        $finish;
    end

    function automatic mnta_pkg::result_t neighbor_outcome(input mnta_pkg::item_t it);
        mnta_pkg::result_t r;
        mnta_pkg::entry_t  fresh;
        int unsigned       i;
        int unsigned       keep;
        int unsigned       removed;
        bit                found;
        r = '0;
        removed = 0;
        found = 1'b0;
        fresh.address       = it.sender_mac;
        fresh.last_seen     = it.now_ms;
        fresh.root_flag     = it.sender_is_root;
        fresh.universe      = it.sender_universe;
        fresh.first_channel = it.sender_start_channel;
        fresh.led_total     = it.sender_led_count;
        if (it.action == mnta_pkg::ACT_RECEIVE)
        begin
            if (it.msg_length < min_len)
                r.status = mnta_pkg::ST_SHORT;
            else
            begin
                for (i = 0; i < nb_count; i++)
                begin
                    if (!found && nb_table[i].address == it.sender_mac)
                    begin
                        nb_table[i] = fresh;
                        r.slot = mnta_pkg::SLOT_W'(i);
                        found = 1'b1;
                    end
                end
                if (found)
                    r.status = mnta_pkg::ST_UPDATED;
                else if (nb_count < mnta_pkg::TABLE_ENTRIES_DEF)
                begin
                    nb_table[nb_count] = fresh;
                    r.slot = mnta_pkg::SLOT_W'(nb_count);
                    nb_count++;
                    r.status = mnta_pkg::ST_INSERTED;
                end
                else
                    r.status = mnta_pkg::ST_FULL;
            end
        end
        else
        begin
            if (it.now_ms - last_beat_ms > beat_interval)
            begin
                r.heartbeat_due = 1'b1;
                last_beat_ms = it.now_ms;
            end
            keep = 0;
            for (i = 0; i < nb_count; i++)
            begin
                if (it.now_ms - nb_table[i].last_seen > stale_limit)
                    removed++;
                else
                begin
                    nb_table[keep] = nb_table[i];
                    keep++;
                end
            end
            nb_count = keep;
            r.status = mnta_pkg::ST_TICK;
            r.removed_count = mnta_pkg::COUNT_W'(removed);
        end
        r.entry_count = mnta_pkg::COUNT_W'(nb_count);
        return r;
    endfunction

    function automatic mnta_pkg::item_t receive_beat(
        input logic [31:0] now, input logic [7:0] len,
        input logic [47:0] mac, input logic root,
        input logic [15:0] uni, input logic [15:0] chan,
        input logic [15:0] leds);
        mnta_pkg::item_t it;
        it.action               = mnta_pkg::ACT_RECEIVE;
        it.now_ms               = now;
        it.msg_length           = len;
        it.sender_mac           = mac;
        it.sender_is_root       = root;
        it.sender_universe      = uni;
        it.sender_start_channel = chan;
        it.sender_led_count     = leds;
        return it;
    endfunction

    // sender fields of a tick carry junk on purpose
    function automatic mnta_pkg::item_t tick_beat(input logic [31:0] now);
        mnta_pkg::item_t it;
        it.action               = mnta_pkg::ACT_TICK;
        it.now_ms               = now;
        it.msg_length           = 8'($urandom());
        it.sender_mac           = 48'({$urandom(), $urandom()});
        it.sender_is_root       = 1'($urandom_range(0, 1));
        it.sender_universe      = 16'($urandom());
        it.sender_start_channel = 16'($urandom());
        it.sender_led_count     = 16'($urandom());
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_beat(input mnta_pkg::item_t it);
        int unsigned gap;
        gap = full_rate ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        in_beat <= it;
        do
            @(posedge clk);
        while (item_stall);
        pending_outcomes.push_back(neighbor_outcome(it));
    endtask

    task automatic quiesce();
        item_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mnta_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mnta_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mnta_pkg::CFG_MIN_MESSAGE_BYTES:     min_len = val[7:0];
            mnta_pkg::CFG_STALE_TIMEOUT_MS:      stale_limit = val;
            mnta_pkg::CFG_HEARTBEAT_INTERVAL_MS: beat_interval = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // result side: compare each beat, then stall for a random hold
    always @(posedge clk)
    begin
        mnta_pkg::result_t want;
        if (result_valid && !result_stall)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch($sformatf("result beat with nothing pending: %h", out_beat));
            else
            begin
                want = pending_outcomes.pop_front();
                if (out_beat.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_beat.status, want.status));
                if (out_beat.slot !== want.slot)
                    report_mismatch($sformatf("slot got %0d want %0d",
                                              out_beat.slot, want.slot));
                if (out_beat.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              out_beat.entry_count, want.entry_count));
                if (out_beat.removed_count !== want.removed_count)
                    report_mismatch($sformatf("removed_count got %0d want %0d",
                                              out_beat.removed_count, want.removed_count));
                if (out_beat.heartbeat_due !== want.heartbeat_due)
                    report_mismatch($sformatf("heartbeat_due got %0d want %0d",
                                              out_beat.heartbeat_due, want.heartbeat_due));
            end
            out_hold = full_rate ? 0 : $urandom_range(0, MAX_IDLE);
        end
        else if (out_hold != 0)
            out_hold--;
        result_stall <= (out_hold != 0);
    end

    task automatic test_short_and_insert();
        send_beat(receive_beat(32'd50, 8'd13, 48'h0000_1234_5678, 1'b1,
                               16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(receive_beat(32'd300, 8'd14, '1, 1'b1, '1, '1, '1));
        send_beat(receive_beat(32'd200, 8'd255, '0, 1'b0, '0, '0, '0));
        send_beat(receive_beat(32'd300, 8'd200, '1, 1'b0, 16'($urandom()),
                               16'($urandom()), 16'($urandom())));
    endtask

    // elapsed equal to the interval is not yet due
    task automatic test_heartbeat_hold();
        send_beat(tick_beat(32'd3000));
    endtask

    task automatic test_table_full();
        int unsigned k;
        for (k = 2; k < mnta_pkg::TABLE_ENTRIES_DEF; k++)
            send_beat(receive_beat((k % 2 != 0) ? 32'd14000 : 32'd4000, 8'(14 + k),
                                   48'h0A00_0000_0000 | 48'(k), 1'($urandom_range(0, 1)),
                                   16'($urandom()), 16'($urandom()), 16'($urandom())));
        send_beat(receive_beat(32'd14200, 8'd40, 48'h0B00_0000_0001, 1'b1,
                               16'($urandom()), 16'($urandom()), 16'($urandom())));
        send_beat(receive_beat(32'd14500, 8'd40, 48'h0A00_0000_000F, 1'b0,
                               16'($urandom()), 16'($urandom()), 16'($urandom())));
    endtask

    task automatic test_stale_compaction();
        send_beat(tick_beat(32'd15000));
    endtask

    task automatic test_register_extremes();
        quiesce();
        write_reg(mnta_pkg::CFG_MIN_MESSAGE_BYTES, 32'hFFFF_FF00);
        send_beat(receive_beat(32'd14500, 8'd0, 48'h0C00_0000_0000, 1'b1,
                               16'($urandom()), 16'($urandom()), 16'($urandom())));
        quiesce();
        write_reg(mnta_pkg::CFG_MIN_MESSAGE_BYTES, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_INDEX, 32'd0);
        send_beat(receive_beat(32'd14500, 8'd254, 48'h0C00_0000_0000, 1'b0,
                               16'($urandom()), 16'($urandom()), 16'($urandom())));
        send_beat(receive_beat(32'd14500, 8'd255, 48'h0C00_0000_0000, 1'b0,
                               16'($urandom()), 16'($urandom()), 16'($urandom())));
        quiesce();
        write_reg(mnta_pkg::CFG_STALE_TIMEOUT_MS, 32'd0);
        write_reg(mnta_pkg::CFG_HEARTBEAT_INTERVAL_MS, 32'd0);
        send_beat(tick_beat(32'd14500));
    endtask

    task automatic run_phase(input logic [7:0] min_b, input logic [31:0] stale,
                             input logic [31:0] beat, input logic [31:0] base,
                             input int unsigned step_max, input bit steady);
        logic [47:0]     pool [POOL_SIZE];
        logic [31:0]     clock_ms;
        logic [31:0]     v;
        logic [7:0]      len;
        mnta_pkg::item_t it;
        int unsigned     n;
        int unsigned     pick;
        quiesce();
        v = $urandom();
        v[7:0] = min_b;
        write_reg(mnta_pkg::CFG_MIN_MESSAGE_BYTES, v);
        write_reg(mnta_pkg::CFG_STALE_TIMEOUT_MS, stale);
        write_reg(mnta_pkg::CFG_HEARTBEAT_INTERVAL_MS, beat);
        full_rate = steady;
        for (n = 0; n < POOL_SIZE; n++)
            pool[n] = 48'({$urandom(), $urandom()});
        clock_ms = base;
        for (n = 0; n < PHASE_BEATS; n++)
        begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                it = tick_beat($urandom());
                it.action = 1'($urandom_range(0, 1));
            end
            else if (pick < 25)
                it = tick_beat(clock_ms);
            else
            begin
                if (min_b != 0 && $urandom_range(0, 9) == 0)
                    len = 8'($urandom_range(0, 32'(min_b) - 1));
                else
                    len = 8'($urandom_range(32'(min_b), 255));
                it = receive_beat(clock_ms, len, pool[$urandom_range(0, POOL_SIZE - 1)],
                                  1'($urandom_range(0, 1)), 16'($urandom()),
                                  16'($urandom()), 16'($urandom()));
            end
            send_beat(it);
        end
        quiesce();
        full_rate = 1'b0;
    endtask

    task automatic test_random_traffic();
        int unsigned p;
        run_phase(8'd14, 32'd10000, 32'd3000, 32'hFFFF_F000, 400, 1'b0);
        run_phase(8'd0, 32'd0, 32'd0, $urandom(), 2, 1'b0);
        run_phase(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom(), 1000, 1'b0);
        run_phase(8'd1, 32'd2000, 32'd500, $urandom(), 300, 1'b1);
        run_phase(8'($urandom()), $urandom(), $urandom(), $urandom(), 1500, 1'b0);
        for (p = 0; p < 3; p++)
            run_phase(8'($urandom()), $urandom_range(50, 20000), $urandom_range(0, 5000),
                      $urandom(), $urandom_range(1, 1500), $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_and_insert();
        test_heartbeat_hold();
        test_table_full();
        test_stale_compaction();
        test_register_extremes();
        test_random_traffic();
        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("** mesh_neighbor_table_aging_unit: PASSED **");
        else
            $display("** mesh_neighbor_table_aging_unit: FAILED **");
        $finish;
    end

endmodule
